// File: src/rlls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlls_pkg
// Shared types and constants for the radial line least-squares fit.
// ----------------------------------------------------------------------------
package rlls_pkg;

  localparam int MAX_POINTS_DEF = 1024;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DEGEN = 2'd1;
  localparam logic [1:0] STATUS_SIGN  = 2'd2;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] intercept;
    logic signed [31:0] slope;
    logic [1:0]         fit_status;
  } out_item_t;

endpackage

// File: src/rlls_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlls_mul
// Iterative signed multiplier, one bit of the second operand per cycle.
// ----------------------------------------------------------------------------
module rlls_mul #(
  parameter int OPW = 44
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [OPW-1:0]     op_a,
  input  logic signed [OPW-1:0]     op_b,
  output logic                      done,
  output logic signed [2*OPW-1:0]   prod
);

  localparam int PW = 2 * OPW;
  localparam int CNW = $clog2(OPW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNW-1:0]  cnt_r, cnt_nxt;
  logic [PW-1:0]   ma_r, ma_nxt;
  logic [OPW-1:0]  mb_r, mb_nxt;
  logic [PW-1:0]   acc_r, acc_nxt;
  logic            neg_r, neg_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      ma_nxt   = PW'(op_a[OPW-1] ? OPW'(-op_a) : OPW'(op_a));
      mb_nxt   = op_b[OPW-1] ? OPW'(-op_b) : OPW'(op_b);
      acc_nxt  = '0;
      neg_nxt  = op_a[OPW-1] ^ op_b[OPW-1];
    end else if (busy_r) begin
      if (mb_r[0]) begin
        acc_nxt = acc_r + ma_r;
      end
      ma_nxt  = {ma_r[PW-2:0], 1'b0};
      mb_nxt  = {1'b0, mb_r[OPW-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNW'(OPW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    acc_r <= acc_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign prod = neg_r ? $signed(-acc_r) : $signed(acc_r);

endmodule

// File: src/rlls_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlls_div
// Restoring divider, one quotient bit per cycle, saturated to 32 bits signed.
// ----------------------------------------------------------------------------
module rlls_div #(
  parameter int NUMW = 105,
  parameter int DENW = 88
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [NUMW-1:0] num,
  input  logic [DENW-1:0]        den,
  output logic                   done,
  output logic signed [31:0]     quot
);

  localparam int CNW = $clog2(NUMW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNW-1:0]  cnt_r, cnt_nxt;
  logic [NUMW-1:0] sh_r, sh_nxt;
  logic [DENW-1:0] rem_r, rem_nxt;
  logic [DENW-1:0] den_r, den_nxt;
  logic [32:0]     q_r, q_nxt;
  logic            ovf_r, ovf_nxt;
  logic            neg_r, neg_nxt;
  logic [DENW:0]   trial;
  logic            ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    neg_nxt  = neg_r;
    trial    = {rem_r, sh_r[NUMW-1]};
    ge       = trial >= {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sh_nxt   = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
      rem_nxt  = '0;
      den_nxt  = den;
      q_nxt    = '0;
      ovf_nxt  = 1'b0;
      neg_nxt  = num[NUMW-1];
    end else if (busy_r) begin
      rem_nxt = ge ? DENW'(trial - {1'b0, den_r}) : DENW'(trial);
      sh_nxt  = {sh_r[NUMW-2:0], 1'b0};
      q_nxt   = {q_r[31:0], ge};
      ovf_nxt = ovf_r | q_r[32];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNW'(NUMW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    if (neg_r) begin
      if (ovf_r || q_r > 33'h080000000) begin
        quot = 32'sh80000000;
      end else begin
        quot = $signed(32'(-q_r));
      end
    end else begin
      if (ovf_r || q_r > 33'h07FFFFFFF) begin
        quot = 32'sh7FFFFFFF;
      end else begin
        quot = $signed(q_r[31:0]);
      end
    end
  end

  assign done = done_r;

endmodule

// File: src/radial_line_least_squares_fit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_line_least_squares_fit
// Least-squares fit of z against radial distance over a set of points.
// ----------------------------------------------------------------------------
// Channel | Direction | Type       | Handshake
// in_     | input     | in_item_t  | in_valid / in_ready
// out_    | output    | out_item_t | out_valid / out_ready
//
// Each point passes through the idle state in which it is accepted, a
// squaring step, 16 square-root iterations and an accumulate step.
// A last point adds six passes of the bit-serial multiplier, two passes
// of the bit-serial divider and the output state; a degenerate set skips
// the divider passes.
// Reset clears the sequencer, the accumulators and the output valid flag.
// A result waits in the output register while the next point is taken.
// ----------------------------------------------------------------------------
module radial_line_least_squares_fit #(
  parameter int MAX_POINTS = rlls_pkg::MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rlls_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rlls_pkg::out_item_t out_item
);

  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int SRW  = 16 + CW;
  localparam int SRRW = 32 + CW;
  localparam int SZW  = 16 + CW;
  localparam int SRZW = 32 + CW;
  localparam int OPW  = SRRW + 1;
  localparam int PW   = 2 * OPW;
  localparam int NUMW = PW + 17;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_ROOT  = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_MULW  = 4'd5;
  localparam logic [3:0] S_DIVA  = 4'd6;
  localparam logic [3:0] S_DIVAW = 4'd7;
  localparam logic [3:0] S_DIVB  = 4'd8;
  localparam logic [3:0] S_DIVBW = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]             state_r, state_nxt;
  logic [15:0]            ax_r, ax_nxt, ay_r, ay_nxt;
  logic signed [15:0]     z_r, z_nxt;
  logic                   last_r, last_nxt;
  logic [31:0]            s_r, s_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [3:0]             it_r, it_nxt;
  logic [2:0]             k_r, k_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [SRW-1:0]         sr_r, sr_nxt;
  logic [SRRW-1:0]        srr_r, srr_nxt;
  logic signed [SZW-1:0]  sz_r, sz_nxt;
  logic signed [SRZW-1:0] srz_r, srz_nxt;
  logic signed [PW-1:0]   p_r [6];
  logic signed [31:0]     a_r, a_nxt, b_r, b_nxt;
  logic [1:0]             st_r, st_nxt;
  logic                   out_valid_r, out_valid_nxt;
  rlls_pkg::out_item_t    out_r, out_nxt;

  logic                   mul_start, mul_done;
  logic signed [OPW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]   mul_p;
  logic                   div_start, div_done;
  logic signed [NUMW-1:0] div_num;
  logic signed [31:0]     div_q;

  logic [31:0]            trial;
  logic [15:0]            root;
  logic [31:0]            rr;
  logic signed [32:0]     rz;
  logic signed [PW-1:0]   den_s, na, nb;
  logic                   degen;
  logic signed [OPW-1:0]  op_n, op_sr, op_srr, op_sz, op_srz;

  assign op_n   = $signed(OPW'(cnt_r));
  assign op_sr  = $signed(OPW'(sr_r));
  assign op_srr = $signed(OPW'(srr_r));
  assign op_sz  = OPW'(sz_r);
  assign op_srz = OPW'(srz_r);

  always_comb begin
    case (k_r)
      3'd0: begin mul_a = op_n;   mul_b = op_srr; end
      3'd1: begin mul_a = op_sr;  mul_b = op_sr;  end
      3'd2: begin mul_a = op_srr; mul_b = op_sz;  end
      3'd3: begin mul_a = op_sr;  mul_b = op_srz; end
      3'd4: begin mul_a = op_n;   mul_b = op_srz; end
      default: begin mul_a = op_sr; mul_b = op_sz; end
    endcase
  end

  assign den_s = p_r[0] - p_r[1];
  assign na    = p_r[2] - p_r[3];
  assign nb    = p_r[4] - p_r[5];
  assign degen = (cnt_r < CW'(2)) || (den_s == '0);

  assign trial = res_r + bit_r;
  assign root  = res_r[15:0];
  assign rr    = root * root;
  assign rz    = $signed({1'b0, root}) * z_r;

  rlls_mul #(.OPW(OPW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  rlls_div #(.NUMW(NUMW), .DENW(PW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (PW'(den_s)),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    z_nxt         = z_r;
    last_nxt      = last_r;
    s_nxt         = s_r;
    res_nxt       = res_r;
    bit_nxt       = bit_r;
    it_nxt        = it_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    sr_nxt        = sr_r;
    srr_nxt       = srr_r;
    sz_nxt        = sz_r;
    srz_nxt       = srz_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    st_nxt        = st_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    div_num       = NUMW'(na) <<< 8;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ax_nxt    = in_item.point_x[15] ? 16'(-in_item.point_x) : in_item.point_x;
          ay_nxt    = in_item.point_y[15] ? 16'(-in_item.point_y) : in_item.point_y;
          z_nxt     = in_item.point_z;
          last_nxt  = in_item.last_point;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        s_nxt     = ax_r * ax_r + ay_r * ay_r;
        res_nxt   = '0;
        bit_nxt   = 32'h40000000;
        it_nxt    = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (s_r >= trial) begin
          s_nxt   = s_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        it_nxt  = it_r + 1'b1;
        if (it_r == 4'd15) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (32'(cnt_r) < 32'(MAX_POINTS)) begin
          cnt_nxt = cnt_r + 1'b1;
          sr_nxt  = sr_r + SRW'(root);
          srr_nxt = srr_r + SRRW'(rr);
          sz_nxt  = sz_r + SZW'(z_r);
          srz_nxt = srz_r + SRZW'(rz);
        end
        k_nxt     = '0;
        state_nxt = last_r ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        mul_start = 1'b1;
        state_nxt = S_MULW;
      end
      S_MULW: begin
        if (mul_done) begin
          k_nxt = k_r + 1'b1;
          if (k_r == 3'd5) begin
            if (degen) begin
              a_nxt     = '0;
              b_nxt     = '0;
              st_nxt    = rlls_pkg::STATUS_DEGEN;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_DIVA;
            end
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_DIVA: begin
        div_start = 1'b1;
        state_nxt = S_DIVAW;
      end
      S_DIVAW: begin
        if (div_done) begin
          a_nxt     = div_q;
          state_nxt = S_DIVB;
        end
      end
      S_DIVB: begin
        div_start = 1'b1;
        div_num   = NUMW'(nb) <<< 16;
        state_nxt = S_DIVBW;
      end
      S_DIVBW: begin
        if (div_done) begin
          b_nxt = div_q;
          if (a_r == '0 || a_r[31] || !div_q[31]) begin
            st_nxt = rlls_pkg::STATUS_SIGN;
          end else begin
            st_nxt = rlls_pkg::STATUS_OK;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.intercept  = a_r;
          out_nxt.slope      = b_r;
          out_nxt.fit_status = st_r;
          out_valid_nxt      = 1'b1;
          cnt_nxt            = '0;
          sr_nxt             = '0;
          srr_nxt            = '0;
          sz_nxt             = '0;
          srz_nxt            = '0;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      sr_r        <= '0;
      srr_r       <= '0;
      sz_r        <= '0;
      srz_r       <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      sr_r        <= sr_nxt;
      srr_r       <= srr_nxt;
      sz_r        <= sz_nxt;
      srz_r       <= srz_nxt;
      k_r         <= k_nxt;
    end
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    z_r    <= z_nxt;
    last_r <= last_nxt;
    s_r    <= s_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    it_r   <= it_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    st_r   <= st_nxt;
    out_r  <= out_nxt;
    if (state_r == S_MULW && mul_done) begin
      p_r[k_r] <= mul_p;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(MAX_POINTS))
    else $error("point count beyond its limit");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.fit_status == rlls_pkg::STATUS_DEGEN |->
      out_item.intercept == '0 && out_item.slope == '0)
    else $error("degenerate result carries a nonzero fit");

  a_ok_signs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.fit_status == rlls_pkg::STATUS_OK |->
      out_item.intercept > 0 && out_item.slope < 0)
    else $error("status ok with failing sign check");

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && (!out_valid_r || out_ready) |=> cnt_r == '0 && sr_r == '0)
    else $error("accumulators not cleared after a result");

endmodule

// File: dv/rlls_fit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlls_fit_checker
// Watches both channels of the radial line fit, keeps its own running sums
// for the current point set, works out the intercept, slope and status that
// a last point should give, and compares each returned fit with the oldest
// one still awaited. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module rlls_fit_checker #(
  parameter int MAX_POINTS = rlls_pkg::MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  rlls_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  rlls_pkg::out_item_t out_item,
  output int                  error_count,
  output int                  pending_count
);

  int unsigned         pts_kept;
  longint unsigned     acc_r;
  longint unsigned     acc_rr;
  longint              acc_z;
  longint              acc_rz;
  rlls_pkg::out_item_t expected_fits[$];

  function automatic logic [31:0] radius_of(logic signed [15:0] x, logic signed [15:0] y);
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] s;
    logic [31:0] res;
    logic [31:0] bitv;
    ax = x < 0 ? 32'(-int'(x)) : 32'(x);
    ay = y < 0 ? 32'(-int'(y)) : 32'(y);
    s = ax * ax + ay * ay;
    res = 0;
    bitv = 32'h4000_0000;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] div_sat(logic signed [127:0] num,
                                                  logic signed [127:0] den);
    logic signed [127:0] q;
    q = num / den;
    if (q > 128'sd2147483647) return 32'h7fff_ffff;
    if (q < -128'sd2147483648) return 32'h8000_0000;
    return q[31:0];
  endfunction

  function automatic rlls_pkg::out_item_t solve_fit();
    rlls_pkg::out_item_t f;
    longint unsigned     d;
    logic signed [127:0] w_n, w_r, w_rr, w_z, w_rz, w_d, na, nb;
    f.intercept  = 0;
    f.slope      = 0;
    f.fit_status = rlls_pkg::STATUS_DEGEN;
    if (pts_kept >= 2) begin
      d = longint'(pts_kept) * acc_rr - acc_r * acc_r;
      if (d != 0) begin
        w_n  = 128'(pts_kept);
        w_r  = 128'(acc_r);
        w_rr = 128'(acc_rr);
        w_z  = acc_z;
        w_rz = acc_rz;
        w_d  = 128'(d);
        na = w_rr * w_z - w_r * w_rz;
        nb = w_n * w_rz - w_r * w_z;
        f.intercept = div_sat(na <<< 8, w_d);
        f.slope     = div_sat(nb <<< 16, w_d);
        if (f.intercept <= 0 || f.slope >= 0) f.fit_status = rlls_pkg::STATUS_SIGN;
        else f.fit_status = rlls_pkg::STATUS_OK;
      end
    end
    return f;
  endfunction

  assign pending_count = expected_fits.size();

  always @(posedge clk) begin
    logic [31:0]         r;
    rlls_pkg::out_item_t e;
    if (!rst_n) begin
      pts_kept <= 0;
      acc_r    <= 0;
      acc_rr   <= 0;
      acc_z    <= 0;
      acc_rz   <= 0;
      error_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (pts_kept < MAX_POINTS) begin
          r = radius_of(in_item.point_x, in_item.point_y);
          pts_kept = pts_kept + 1;
          acc_r    = acc_r + r;
          acc_rr   = acc_rr + longint'(r) * longint'(r);
          acc_z    = acc_z + in_item.point_z;
          acc_rz   = acc_rz + longint'(r) * longint'(in_item.point_z);
        end
        if (in_item.last_point) begin
          expected_fits.push_back(solve_fit());
          pts_kept = 0;
          acc_r    = 0;
          acc_rr   = 0;
          acc_z    = 0;
          acc_rz   = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_fits.size() == 0) begin
          $display("%0t: unexpected fit, actual %0d %0d %0d", $time,
                   out_item.intercept, out_item.slope, out_item.fit_status);
          error_count <= error_count + 1;
        end else begin
          e = expected_fits.pop_front();
          if (e.intercept !== out_item.intercept || e.slope !== out_item.slope ||
              e.fit_status !== out_item.fit_status) begin
            $display("%0t: fit expected %0d %0d %0d, actual %0d %0d %0d", $time,
                     e.intercept, e.slope, e.fit_status,
                     out_item.intercept, out_item.slope, out_item.fit_status);
            error_count <= error_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: dv/radial_line_least_squares_fit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_line_least_squares_fit_tb
// Drives point sets into the radial line fit: a few directed sets covering
// degenerate sets, equal radii and coordinate extremes, then random sets of
// noisy cone points and raw values, one set long enough to overflow the point
// limit, under three patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module radial_line_least_squares_fit_tb;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  rlls_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  rlls_pkg::out_item_t out_item;
  int                  error_count;
  int                  pending_count;
  int                  send_gap_pct;
  int                  recv_stall_pct;
  int                  points_sent;

  radial_line_least_squares_fit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  rlls_fit_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z, logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{point_x: x, point_y: y, point_z: z, last_point: last};
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    points_sent++;
  endtask

  task automatic send_random_set(int len);
    int base;
    int slope;
    int noise;
    int kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    base  = $urandom_range(32767);
    slope = $urandom_range(8);
    noise = $urandom_range(512);
    kind  = $urandom_range(3);
    for (int i = 0; i < len; i++) begin
      if (kind == 0) begin
        send_point(16'($urandom), 16'($urandom), 16'($urandom), i == len - 1);
      end else begin
        x = $signed(16'($urandom_range(8191))) - 16'sd4096;
        y = $signed(16'($urandom_range(8191))) - 16'sd4096;
        send_point(x, y, 16'(base - slope * ((x < 0 ? -x : x) + (y < 0 ? -y : y)) / 2
                             + $signed($urandom_range(2 * noise)) - noise),
                   i == len - 1);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    wait (pending_count == 0);
    repeat (3000) @(posedge clk);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    out_ready      = 1'b0;
    points_sent    = 0;
    send_gap_pct   = 12;
    recv_stall_pct = 75;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_point(16'sd300, -16'sd200, 16'sd100, 1'b1);
    send_point(16'sd256, 16'sd0, 16'sd50, 1'b0);
    send_point(16'sd0, 16'sd256, 16'sd900, 1'b1);
    send_point(-16'sd32768, -16'sd32768, 16'sd32767, 1'b0);
    send_point(16'sd32767, 16'sd32767, -16'sd32768, 1'b0);
    send_point(16'sd0, 16'sd0, -16'sd32768, 1'b0);
    send_point(-16'sd32768, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd0, -16'sd32768, 16'sd32767, 1'b1);
    send_point(16'sd0, 16'sd0, 16'sd2560, 1'b0);
    send_point(16'sd256, 16'sd0, 16'sd2304, 1'b0);
    send_point(16'sd0, -16'sd512, 16'sd2048, 1'b0);
    send_point(-16'sd768, 16'sd0, 16'sd1792, 1'b1);
    send_point(16'sd1, 16'sd0, -16'sd32768, 1'b0);
    send_point(-16'sd32768, -16'sd32768, 16'sd32767, 1'b1);
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);

    while (points_sent < 320) send_random_set($urandom_range(1, 14));

    drain();
    send_gap_pct   = 75;
    recv_stall_pct = 12;
    while (points_sent < 640) send_random_set($urandom_range(1, 14));

    drain();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_random_set(1030);
    while (points_sent < 1750) send_random_set($urandom_range(1, 14));

    drain();
    if (error_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
src/rlls_pkg.sv
src/rlls_mul.sv
src/rlls_div.sv
src/radial_line_least_squares_fit.sv
dv/rlls_fit_checker.sv
dv/radial_line_least_squares_fit_tb.sv
